[rtl/core/stp_pkg.sv]
// spectrum trace processor shared package
// opcodes, view modes, controller command/status structs; no dependencies
package stp_pkg;

  localparam int OP_W       = 3;
  localparam int IDX_W      = 7;
  localparam int RSSI_W     = 8;
  localparam int SUM_W      = 24;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [OP_W-1:0] OP_SWEEP    = 3'd0;
  localparam logic [OP_W-1:0] OP_POINT    = 3'd1;
  localparam logic [OP_W-1:0] OP_BASE     = 3'd2;
  localparam logic [OP_W-1:0] OP_RST_MAX  = 3'd3;
  localparam logic [OP_W-1:0] OP_RST_AVG  = 3'd4;
  localparam logic [OP_W-1:0] OP_CLR_BASE = 3'd5;
  localparam logic [OP_W-1:0] OP_PAUSE    = 3'd6;
  localparam logic [OP_W-1:0] OP_REARM    = 3'd7;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_MAX    = 2'd1;
  localparam logic [1:0] MODE_AVG    = 2'd2;
  localparam logic [1:0] MODE_DIFF   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_VIEW_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_EN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_LVL  = 2'd2;

  localparam logic [CNT_W-1:0]  COUNT_MAX   = 16'hFFFF;
  localparam logic [SUM_W-1:0]  SUM_MAX     = 24'hFFFFFF;
  localparam logic [RSSI_W-1:0] REARM_HYST  = 8'd5;
  localparam logic [RSSI_W-1:0] LEVEL_RESET = 8'd100;

  // controller to datapath
  typedef struct packed {
    logic exec;      // run the item's state update, read stores
    logic div_start; // start the average divider
    logic wb;        // write store entry, latch result
  } stp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } stp_sts_t;

endpackage

[rtl/core/stp_div.sv]
// restoring divider, one quotient bit per cycle, 24 by 16 bits
// depends on stp_pkg
module stp_div
  import stp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W:0]    trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[CNT_W-1:0], quo_r[SUM_W-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      step_nxt = STEP_W'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[rtl/core/stp_datapath.sv]
// datapath: stores, valid bits, trigger state, display value, result register
// depends on stp_pkg, stp_div
module stp_datapath
  import stp_pkg::*;
#(
  parameter int POINTS = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  stp_cmd_t          cmd,
  output stp_sts_t          sts,
  input  logic [1:0]        view_mode,
  input  logic              trig_en,
  input  logic [RSSI_W-1:0] trig_level,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [IDX_W-1:0]  in_point_index,
  input  logic [RSSI_W-1:0] in_rssi,
  input  logic [RSSI_W-1:0] in_sweep_peak,
  input  logic              in_pause_value,
  output logic [RSSI_W-1:0] out_display_value,
  output logic              out_value_valid,
  output logic              out_trigger_fired,
  output logic              out_accumulating,
  output logic              out_armed,
  output logic              out_paused,
  output logic              out_baseline_present,
  output logic [CNT_W-1:0]  out_sweep_count
);

  localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1;

  logic [RSSI_W-1:0] max_mem  [POINTS];
  logic [SUM_W-1:0]  sum_mem  [POINTS];
  logic [RSSI_W-1:0] base_mem [POINTS];
  logic [POINTS-1:0] max_v_r, sum_v_r, base_v_r;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic armed_r, armed_nxt, pause_r, pause_nxt;
  logic bflag_r, bflag_nxt, acc_r, acc_nxt;
  logic fired_nxt;

  // item latched at exec
  logic [OP_W-1:0]   op_q;
  logic [RSSI_W-1:0] rssi_q;
  logic              inr_q;
  logic [AW-1:0]     addr_q;
  logic [RSSI_W-1:0] max_rd_q, base_rd_q;
  logic [SUM_W-1:0]  sum_rd_q;
  logic              max_v_q, sum_v_q, base_v_q;
  logic              fired_q;

  logic              in_range;
  logic [AW-1:0]     addr;
  logic [RSSI_W-1:0] max_cur, base_cur, max_new;
  logic [SUM_W-1:0]  sum_cur, sum_new;
  logic [SUM_W:0]    sum_add;
  logic              upd;
  logic              div_done;
  logic [SUM_W-1:0]  quo;
  logic [RSSI_W-1:0] disp;
  logic              vld;

  assign in_range = (32'(in_point_index) < POINTS);
  assign addr     = AW'(in_point_index);

  // trigger, pause, baseline flag, accumulate flag and count update
  always_comb begin
    count_nxt = count_r;
    armed_nxt = armed_r;
    pause_nxt = pause_r;
    bflag_nxt = bflag_r;
    acc_nxt   = acc_r;
    fired_nxt = 1'b0;
    case (in_opcode)
      OP_SWEEP: begin
        if (trig_en && !pause_r) begin
          if (!armed_r) begin
            if ({1'b0, in_sweep_peak} + {1'b0, REARM_HYST} < {1'b0, trig_level})
              armed_nxt = 1'b1;
          end else if (in_sweep_peak >= trig_level) begin
            armed_nxt = 1'b0;
            pause_nxt = 1'b1;
            fired_nxt = 1'b1;
          end
        end
        acc_nxt = !trig_en && !pause_nxt &&
                  !(view_mode == MODE_AVG && count_r == COUNT_MAX);
        if (acc_nxt && view_mode == MODE_AVG) count_nxt = count_r + 1'b1;
      end
      OP_BASE:     bflag_nxt = 1'b1;
      OP_RST_AVG:  count_nxt = '0;
      OP_CLR_BASE: bflag_nxt = 1'b0;
      OP_PAUSE:    pause_nxt = in_pause_value;
      OP_REARM:    armed_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      armed_r  <= 1'b1;
      pause_r  <= 1'b0;
      bflag_r  <= 1'b0;
      acc_r    <= 1'b0;
      max_v_r  <= '0;
      sum_v_r  <= '0;
      base_v_r <= '0;
      fired_q  <= 1'b0;
    end else begin
      if (cmd.exec) begin
        count_r <= count_nxt;
        armed_r <= armed_nxt;
        pause_r <= pause_nxt;
        bflag_r <= bflag_nxt;
        acc_r   <= acc_nxt;
        fired_q <= fired_nxt;
        case (in_opcode)
          OP_BASE:     if (in_range) base_v_r[addr] <= 1'b1;
          OP_RST_MAX:  max_v_r  <= '0;
          OP_RST_AVG:  sum_v_r  <= '0;
          OP_CLR_BASE: base_v_r <= '0;
          default: ;
        endcase
      end
      if (cmd.wb && upd) begin
        if (view_mode == MODE_MAX) max_v_r[addr_q] <= 1'b1;
        if (view_mode == MODE_AVG) sum_v_r[addr_q] <= 1'b1;
      end
    end
  end

  // registered memory reads and writes
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      op_q      <= in_opcode;
      rssi_q    <= in_rssi;
      inr_q     <= in_range;
      addr_q    <= addr;
      max_rd_q  <= max_mem[addr];
      sum_rd_q  <= sum_mem[addr];
      base_rd_q <= base_mem[addr];
      max_v_q   <= max_v_r[addr];
      sum_v_q   <= sum_v_r[addr];
      base_v_q  <= base_v_r[addr];
      if (in_opcode == OP_BASE && in_range) base_mem[addr] <= in_rssi;
    end
    if (cmd.wb && upd) begin
      if (view_mode == MODE_MAX) max_mem[addr_q] <= max_new;
      if (view_mode == MODE_AVG) sum_mem[addr_q] <= sum_new;
    end
  end

  assign max_cur  = (inr_q && max_v_q)  ? max_rd_q  : '0;
  assign sum_cur  = (inr_q && sum_v_q)  ? sum_rd_q  : '0;
  assign base_cur = (inr_q && base_v_q) ? base_rd_q : '0;
  assign upd      = (op_q == OP_POINT) && acc_r && inr_q;
  assign max_new  = (rssi_q > max_cur) ? rssi_q : max_cur;
  assign sum_add  = {1'b0, sum_cur} + (SUM_W + 1)'(rssi_q);
  assign sum_new  = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

  stp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (upd ? sum_new : sum_cur),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (quo)
  );

  assign sts.need_div = (op_q == OP_POINT) && (view_mode == MODE_AVG) && (count_r != '0);
  assign sts.div_done = div_done;

  always_comb begin
    disp = '0;
    vld  = 1'b0;
    if (op_q == OP_POINT) begin
      vld = !(view_mode == MODE_AVG && count_r == '0);
      case (view_mode)
        MODE_MAX: disp = upd ? max_new : max_cur;
        MODE_AVG: disp = (count_r == '0) ? '0 :
                         (quo > SUM_W'(8'hFF)) ? 8'hFF : quo[RSSI_W-1:0];
        MODE_DIFF: begin
          if (!bflag_r) disp = rssi_q;
          else disp = (rssi_q > base_cur) ? rssi_q - base_cur : '0;
        end
        default: disp = rssi_q;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      out_display_value    <= disp;
      out_value_valid      <= vld;
      out_trigger_fired    <= fired_q;
      out_accumulating     <= acc_r;
      out_armed            <= armed_r;
      out_paused           <= pause_r;
      out_baseline_present <= bflag_r;
      out_sweep_count      <= count_r;
    end
  end

endmodule

[rtl/core/stp_ctrl.sv]
// controller state machine: item handshake and datapath sequencing
// depends on stp_pkg
module stp_ctrl
  import stp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output stp_cmd_t cmd,
  input  stp_sts_t sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;
  logic       take;

  // a new item waits while an item is being processed or an older result is still held
  assign in_stall = (state_r != S_IDLE) || ov_r;
  assign take     = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    ov_nxt        = ov_r && out_stall;
    cmd.exec      = take;
    cmd.div_start = 1'b0;
    cmd.wb        = 1'b0;
    case (state_r)
      S_IDLE: if (take) state_nxt = S_RD;
      S_RD: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.wb    = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: if (sts.div_done) begin
        cmd.wb    = 1'b1;
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;

endmodule

[rtl/core/spectrum_trace_processor.sv]
// spectrum trace processor top level: config registers, controller, datapath
// depends on stp_pkg, stp_ctrl, stp_datapath
//
// usage:
//   input channel in_valid/in_stall carries one item (opcode, point index,
//   rssi, sweep peak, pause value); every item yields exactly one result item
//   on out_valid/out_stall holding the display value and status flags.
//   config registers (view mode, trigger enable, trigger level) are written
//   through cfg_we/cfg_index/cfg_data; the user must write them only while
//   the block is idle, the block itself does not enforce this.
//   a point item in average mode with a nonzero count runs the 24-step
//   serial divider before its result is written. one item is in flight at
//   a time, the next is taken the cycle after the result is read.
//   reset: max-hold, average and baseline valid bits clear at once, the
//   trigger is armed, pause, baseline flag and sweep count clear.
//   a stalled result stays in the output register and in_stall stays high.
module spectrum_trace_processor
  import stp_pkg::*;
#(
  parameter int POINTS = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_opcode,
  input  logic [IDX_W-1:0]      in_point_index,
  input  logic [RSSI_W-1:0]     in_rssi,
  input  logic [RSSI_W-1:0]     in_sweep_peak,
  input  logic                  in_pause_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [RSSI_W-1:0]     out_display_value,
  output logic                  out_value_valid,
  output logic                  out_trigger_fired,
  output logic                  out_accumulating,
  output logic                  out_armed,
  output logic                  out_paused,
  output logic                  out_baseline_present,
  output logic [CNT_W-1:0]      out_sweep_count,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [1:0]        view_mode_r;
  logic              trig_en_r;
  logic [RSSI_W-1:0] trig_level_r;
  stp_cmd_t          cmd;
  stp_sts_t          sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_mode_r  <= MODE_NORMAL;
      trig_en_r    <= 1'b0;
      trig_level_r <= LEVEL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VIEW_MODE: view_mode_r  <= cfg_data[1:0];
        REG_TRIG_EN:   trig_en_r    <= cfg_data[0];
        REG_TRIG_LVL:  trig_level_r <= cfg_data;
        default: ;
      endcase
    end
  end

  stp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  stp_datapath #(.POINTS(POINTS)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .view_mode            (view_mode_r),
    .trig_en              (trig_en_r),
    .trig_level           (trig_level_r),
    .in_opcode            (in_opcode),
    .in_point_index       (in_point_index),
    .in_rssi              (in_rssi),
    .in_sweep_peak        (in_sweep_peak),
    .in_pause_value       (in_pause_value),
    .out_display_value    (out_display_value),
    .out_value_valid      (out_value_valid),
    .out_trigger_fired    (out_trigger_fired),
    .out_accumulating     (out_accumulating),
    .out_armed            (out_armed),
    .out_paused           (out_paused),
    .out_baseline_present (out_baseline_present),
    .out_sweep_count      (out_sweep_count)
  );

endmodule

[rtl/core/stp_checker.sv]
// port-level checker for spectrum_trace_processor, bound to the top level
// depends on stp_pkg
module stp_checker
  import stp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_value_valid,
  input logic              out_trigger_fired,
  input logic              out_armed,
  input logic              out_paused,
  input logic [RSSI_W-1:0] out_display_value
);

  // one item in flight: no item taken while a result is pending
  a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("item accepted while result pending");

  // fired trigger disarms and pauses
  a_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_trigger_fired) |-> (!out_armed && out_paused))
    else $error("trigger fired without pause");

  // invalid value shows zero
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_value_valid) |-> (out_display_value == '0))
    else $error("display value nonzero while not valid");

  // a stalled result stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_display_value)))
    else $error("stalled result changed");

endmodule

bind spectrum_trace_processor stp_checker u_stp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_value_valid   (out_value_valid),
  .out_trigger_fired (out_trigger_fired),
  .out_armed         (out_armed),
  .out_paused        (out_paused),
  .out_display_value (out_display_value)
);
